@@ rtl/ilp_pkg.sv @@
package ilp_pkg;

    typedef enum logic [3:0] {
        PH_SKIP,
        PH_DEC,
        PH_ZERO,
        PH_OCT,
        PH_BIN,
        PH_HEX,
        PH_DRAIN
    } ilp_phase_t;

    typedef struct packed {
        ilp_phase_t phase;
        logic       negative;
        logic       have_digit;
        logic       failed;
    } ilp_flags_t;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    localparam int RESULT_BITS = 32;

endpackage

@@ rtl/ilp_step.sv @@
module ilp_step
    import ilp_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic [7:0]                   ch,
    input  ilp_flags_t                   flags_in,
    input  logic [VALUE_BITS-1:0]        acc_in,
    output ilp_flags_t                   flags_out,
    output logic [VALUE_BITS-1:0]        acc_out,
    output logic                         emit,
    output logic                         ok,
    output logic signed [RESULT_BITS-1:0] value
);

    logic                  is_ws;
    logic                  term;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] digit_ext;
    logic [VALUE_BITS-1:0] acc_dec;
    logic [VALUE_BITS-1:0] acc_oct;
    logic [VALUE_BITS-1:0] acc_bin;
    logic [VALUE_BITS-1:0] acc_hex;
    logic [VALUE_BITS-1:0] signed_acc;
    logic [RESULT_BITS-1:0] wide_val;
    logic                  good;

    assign is_ws = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
    assign term  = (ch == CH_NUL) || is_ws;

    always_comb begin
        digit = 4'(ch - CH_0);
        if ((ch >= CH_LA) && (ch <= CH_LF)) begin
            digit = 4'(ch - CH_LA + HEX_TEN);
        end else if ((ch >= CH_UA) && (ch <= CH_UF)) begin
            digit = 4'(ch - CH_UA + HEX_TEN);
        end
    end

    assign digit_ext = {{(VALUE_BITS-4){1'b0}}, digit};
    assign acc_dec = (acc_in << 3) + (acc_in << 1) + digit_ext;
    assign acc_oct = (acc_in << 3) + digit_ext;
    assign acc_bin = (acc_in << 1) + digit_ext;
    assign acc_hex = (acc_in << 4) + digit_ext;

    assign signed_acc = flags_in.negative ? (~acc_in + 1'b1) : acc_in;

    generate
        if (VALUE_BITS >= RESULT_BITS) begin : g_trunc
            assign wide_val = signed_acc[RESULT_BITS-1:0];
        end else begin : g_sext
            assign wide_val = {{(RESULT_BITS-VALUE_BITS){signed_acc[VALUE_BITS-1]}},
                               signed_acc};
        end
    endgenerate

    always_comb begin
        flags_out = flags_in;
        acc_out   = acc_in;
        emit      = 1'b0;
        good      = 1'b0;
        case (flags_in.phase)
            PH_SKIP: begin
                flags_out.negative   = 1'b0;
                flags_out.have_digit = 1'b0;
                flags_out.failed     = 1'b0;
                acc_out              = '0;
                if (ch == CH_NUL) begin
                    emit = 1'b1;
                end else if (!is_ws) begin
                    if (ch == CH_0) begin
                        flags_out.phase = PH_ZERO;
                    end else begin
                        flags_out.phase = PH_DEC;
                        if (ch == CH_MINUS) begin
                            flags_out.negative = 1'b1;
                        end else if (ch inside {[CH_1:CH_9]}) begin
                            acc_out              = digit_ext;
                            flags_out.have_digit = 1'b1;
                        end else begin
                            flags_out.failed = 1'b1;
                        end
                    end
                end
            end
            PH_DRAIN: begin
                if (ch == CH_NUL) begin
                    flags_out.phase = PH_SKIP;
                end
            end
            default: begin
                if (term) begin
                    emit = 1'b1;
                    good = !flags_in.failed;
                    if (flags_in.phase inside {PH_DEC, PH_BIN, PH_HEX}) begin
                        good = good && flags_in.have_digit;
                    end
                    flags_out.phase      = (ch == CH_NUL) ? PH_SKIP : PH_DRAIN;
                    flags_out.negative   = 1'b0;
                    flags_out.have_digit = 1'b0;
                    flags_out.failed     = 1'b0;
                    acc_out              = '0;
                end else if (!flags_in.failed) begin
                    case (flags_in.phase)
                        PH_ZERO: begin
                            if (ch == CH_LB) begin
                                flags_out.phase = PH_BIN;
                            end else if (ch == CH_LX) begin
                                flags_out.phase = PH_HEX;
                            end else begin
                                flags_out.phase = PH_OCT;
                                if (ch == CH_MINUS) begin
                                    flags_out.negative = 1'b1;
                                end else if (ch inside {[CH_0:CH_7]}) begin
                                    acc_out              = acc_oct;
                                    flags_out.have_digit = 1'b1;
                                end else begin
                                    flags_out.failed = 1'b1;
                                end
                            end
                        end
                        PH_DEC: begin
                            if (ch inside {[CH_0:CH_9]}) begin
                                acc_out              = acc_dec;
                                flags_out.have_digit = 1'b1;
                            end else begin
                                flags_out.failed = 1'b1;
                            end
                        end
                        PH_OCT: begin
                            if (ch inside {[CH_0:CH_7]}) begin
                                acc_out              = acc_oct;
                                flags_out.have_digit = 1'b1;
                            end else begin
                                flags_out.failed = 1'b1;
                            end
                        end
                        PH_BIN: begin
                            if (ch inside {CH_0, CH_1}) begin
                                acc_out              = acc_bin;
                                flags_out.have_digit = 1'b1;
                            end else begin
                                flags_out.failed = 1'b1;
                            end
                        end
                        PH_HEX: begin
                            if (ch inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
                                acc_out              = acc_hex;
                                flags_out.have_digit = 1'b1;
                            end else begin
                                flags_out.failed = 1'b1;
                            end
                        end
                        default: begin
                            flags_out.phase = PH_SKIP;
                        end
                    endcase
                end
            end
        endcase
    end

    assign ok    = good;
    assign value = good ? wide_val : '0;

endmodule

@@ rtl/int_literal_parser_unit.sv @@
// channel  | valid    | ready    | payload
// input    | s_valid  | s_ready  | s_ch
// result   | m_valid  | m_ready  | m_ok, m_value
//
// one character per cycle while a stalled result does not hold the input; the character
// that ends the token is held in the input register, then its result in the result register
// the step logic is a shift-add multiply by the radix plus a digit add
// aresetn is synchronous; it empties both registers and returns to whitespace skip
// a stalled result holds the result register; the input register still
// advances for characters that give no result
module int_literal_parser_unit
    import ilp_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_ch,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic signed [RESULT_BITS-1:0] m_value
);

    logic                          in_valid_reg;
    logic [7:0]                    ch_reg;
    ilp_flags_t                    flags_reg;
    ilp_flags_t                    flags_next;
    logic [VALUE_BITS-1:0]         acc_reg;
    logic [VALUE_BITS-1:0]         acc_next;
    logic                          m_valid_reg;
    logic                          m_ok_reg;
    logic signed [RESULT_BITS-1:0] m_value_reg;

    logic                          step_emit;
    logic                          step_ok;
    logic signed [RESULT_BITS-1:0] step_value;
    logic                          out_free;
    logic                          step_fire;

    ilp_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .ch       (ch_reg),
        .flags_in (flags_reg),
        .acc_in   (acc_reg),
        .flags_out(flags_next),
        .acc_out  (acc_next),
        .emit     (step_emit),
        .ok       (step_ok),
        .value    (step_value)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign step_fire = in_valid_reg && (!step_emit || out_free);
    assign s_ready   = !in_valid_reg || step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            flags_reg    <= '{phase: PH_SKIP, negative: 1'b0, have_digit: 1'b0,
                              failed: 1'b0};
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step_fire) begin
                flags_reg <= flags_next;
                acc_reg   <= acc_next;
            end
            if (step_fire && step_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
        if (step_fire && step_emit) begin
            m_ok_reg    <= step_ok;
            m_value_reg <= step_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_ok    = m_ok_reg;
    assign m_value = m_value_reg;

endmodule

@@ rtl/ilp_checker.sv @@
module ilp_checker
    import ilp_pkg::*;
(
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [7:0]                    s_ch,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_ok,
    input logic signed [RESULT_BITS-1:0] m_value
);

    // stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_value))
        else $error("result changed while stalled");

    // failed parse reports zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_value == '0)
        else $error("error result with nonzero value");

    // empty output side never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with result register empty");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled input transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_ch))
        else $error("input changed while stalled");

endmodule

bind int_literal_parser_unit ilp_checker u_ilp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_ch    (s_ch),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_ok    (m_ok),
    .m_value (m_value)
);

@@ sim/int_literal_parser_unit_test.sv @@
`timescale 1ns / 100ps

module int_literal_parser_unit_test
    import ilp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 400;
    localparam int RANDOM_CHARS   = 430;

    class literal_scoreboard;

        typedef struct {
            bit                     ok;
            logic [RESULT_BITS-1:0] value;
        } literal_result_t;

        ilp_phase_t             phase;
        logic [RESULT_BITS-1:0] acc;
        bit                     negative;
        bit                     have_digit;
        bit                     failed;
        literal_result_t        literal_q[$];
        int                     errors;
        int                     chars_noted;
        int                     results_checked;

        function new();
            phase = PH_SKIP;
            clear_token();
            errors = 0;
            chars_noted = 0;
            results_checked = 0;
        endfunction

        function bit is_space(logic [7:0] c);
            return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
        endfunction

        function void clear_token();
            acc = '0;
            negative = 1'b0;
            have_digit = 1'b0;
            failed = 1'b0;
        endfunction

        function void add_digit(int unsigned radix, logic [7:0] d);
            acc = acc * radix + d;
            have_digit = 1'b1;
        endfunction

        function void push_result(bit good);
            literal_result_t r;
            r.ok = good;
            r.value = good ? (negative ? -acc : acc) : '0;
            literal_q.push_back(r);
        endfunction

        // accepted input transaction
        function void note_input(logic [7:0] c);
            bit term;
            bit good;
            term = (c == CH_NUL) || is_space(c);
            chars_noted++;
            case (phase)
                PH_SKIP: begin
                    clear_token();
                    if (c == CH_NUL) begin
                        push_result(1'b0);
                    end else if (!is_space(c)) begin
                        if (c == CH_0) begin
                            phase = PH_ZERO;
                        end else begin
                            phase = PH_DEC;
                            if (c == CH_MINUS)
                                negative = 1'b1;
                            else if (c >= CH_0 && c <= CH_9)
                                add_digit(10, c - CH_0);
                            else
                                failed = 1'b1;
                        end
                    end
                    return;
                end
                PH_DRAIN: begin
                    if (c == CH_NUL)
                        phase = PH_SKIP;
                    return;
                end
                default: ;
            endcase

            if (term) begin
                good = !failed;
                if (phase inside {PH_DEC, PH_BIN, PH_HEX})
                    good = good && have_digit;
                push_result(good);
                phase = (c == CH_NUL) ? PH_SKIP : PH_DRAIN;
                clear_token();
                return;
            end

            if (failed)
                return;

            case (phase)
                PH_ZERO: begin
                    if (c == CH_LB) begin
                        phase = PH_BIN;
                    end else if (c == CH_LX) begin
                        phase = PH_HEX;
                    end else begin
                        phase = PH_OCT;
                        if (c == CH_MINUS)
                            negative = 1'b1;
                        else if (c >= CH_0 && c <= CH_7)
                            add_digit(8, c - CH_0);
                        else
                            failed = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (c >= CH_0 && c <= CH_9)
                        add_digit(10, c - CH_0);
                    else
                        failed = 1'b1;
                end
                PH_OCT: begin
                    if (c >= CH_0 && c <= CH_7)
                        add_digit(8, c - CH_0);
                    else
                        failed = 1'b1;
                end
                PH_BIN: begin
                    if (c == CH_0 || c == CH_1)
                        add_digit(2, c - CH_0);
                    else
                        failed = 1'b1;
                end
                PH_HEX: begin
                    if (c >= CH_0 && c <= CH_9)
                        add_digit(16, c - CH_0);
                    else if (c >= CH_LA && c <= CH_LF)
                        add_digit(16, c - CH_LA + HEX_TEN);
                    else if (c >= CH_UA && c <= CH_UF)
                        add_digit(16, c - CH_UA + HEX_TEN);
                    else
                        failed = 1'b1;
                end
                default: phase = PH_SKIP;
            endcase
        endfunction

        // accepted result transaction
        function void check_result(bit ok, logic [RESULT_BITS-1:0] value);
            literal_result_t r;
            results_checked++;
            if (literal_q.size() == 0) begin
                $display("%0t: unexpected result, ok %0d value %0d", $time, ok,
                         $signed(value));
                errors++;
                return;
            end
            r = literal_q.pop_front();
            if (ok !== r.ok) begin
                $display("%0t: ok mismatch, expected %0d actual %0d", $time, r.ok, ok);
                errors++;
            end
            if (value !== r.value) begin
                $display("%0t: value mismatch, expected %0d actual %0d", $time,
                         $signed(r.value), $signed(value));
                errors++;
            end
        endfunction

    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_ch = 8'd0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_ok;
    logic signed [RESULT_BITS-1:0] m_value;

    literal_scoreboard sb = new();
    logic [7:0]        char_q[$];
    bit                tx_burst;
    int                tx_count;

    int_literal_parser_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_ch    (s_ch),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_ok    (m_ok),
        .m_value (m_value)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] space_char();
        if ($urandom_range(0, 6) == 6)
            return CH_SPACE;
        return CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    // one string: mostly a well-formed literal with random content
    function automatic void add_string();
        int kind;
        int n;
        int start;
        int d;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) char_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) char_q.push_back(space_char());
        start = char_q.size();
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            if ($urandom_range(0, 2) == 0)
                char_q.push_back(CH_MINUS);
            char_q.push_back(CH_1 + 8'($urandom_range(0, 8)));
            repeat ($urandom_range(0, 11)) char_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end else if (kind <= 5) begin
            char_q.push_back(CH_0);
            if ($urandom_range(0, 2) == 0)
                char_q.push_back(CH_MINUS);
            repeat ($urandom_range(0, 12)) char_q.push_back(CH_0 + 8'($urandom_range(0, 7)));
        end else if (kind <= 7) begin
            char_q.push_back(CH_0);
            char_q.push_back(CH_LX);
            n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9);
            repeat (n) begin
                d = $urandom_range(0, 15);
                if (d < 10)
                    char_q.push_back(CH_0 + 8'(d));
                else
                    char_q.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10));
            end
        end else begin
            char_q.push_back(CH_0);
            char_q.push_back(CH_LB);
            n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 34);
            repeat (n) char_q.push_back(CH_0 + 8'($urandom_range(0, 1)));
        end
        // broken literal
        if ($urandom_range(0, 6) == 0)
            char_q[$urandom_range(start, char_q.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
            char_q.push_back(CH_NUL);
        end else begin
            char_q.push_back(space_char());
            repeat ($urandom_range(0, 3)) char_q.push_back(8'($urandom_range(1, 255)));
            char_q.push_back(CH_NUL);
        end
    endfunction

    task automatic send_char(logic [7:0] c);
        int gap;
        bit fire;
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= c;
        do begin
            @(negedge aclk);
            fire = s_ready;
            @(posedge aclk);
        end while (!fire);
        sb.note_input(c);
        tx_count++;
    endtask

    task automatic send_queued();
        while (char_q.size() != 0)
            send_char(char_q.pop_front());
    endtask

    task automatic receive_results();
        int gap;
        bit fire;
        bit ok;
        logic [RESULT_BITS-1:0] value;
        bit rx_burst;
        rx_burst = 1'b0;
        forever begin
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                fire = m_valid;
                ok = m_ok;
                value = m_value;
                @(posedge aclk);
            end while (!fire);
            sb.check_result(ok, value);
        end
    endtask

    initial begin
        int idle;
        wait (aresetn);
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("int_literal_parser_unit verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            receive_results();
        join_none

        tx_burst = 1'b0;
        tx_count = 0;
        // empty string, lone zero with trailing text, lone minus, bad prefixes,
        // octal minus, mixed-case hex, high byte, misplaced minus
        char_q = {CH_NUL,
                  CH_0, CH_TAB, CH_LX, CH_NUL,
                  CH_MINUS, CH_NUL,
                  CH_0, CH_LB, CH_SPACE, CH_NUL,
                  CH_0, CH_MINUS, CH_7, CH_NUL,
                  CH_0, "B", CH_1, CH_NUL,
                  CH_0, CH_LX, CH_LF, CH_UF, CH_CR, CH_NUL,
                  8'hff, CH_NUL,
                  CH_9, CH_MINUS, CH_NUL};
        send_queued();

        while (tx_count < RANDOM_CHARS) begin
            add_string();
            send_queued();
        end
        s_valid <= 1'b0;

        while (sb.literal_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d characters, checked %0d literal results, %0d mismatches",
                 sb.chars_noted, sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("int_literal_parser_unit verification clean");
        else
            $display("int_literal_parser_unit verification failed");
        $finish;
    end

endmodule
